@@ sv/noa_pkg.sv @@
// Package for the node operation ALU: opcodes, payload structs and constants.
// Used by every module of the block; depends on nothing.
package noa_pkg;
	localparam int FRACTION_BITS = 16;
	localparam int SLOT_COUNT = 3;
	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam logic [4:0] OP_AND = 5'd0;
	localparam logic [4:0] OP_OR = 5'd1;
	localparam logic [4:0] OP_XOR = 5'd2;
	localparam logic [4:0] OP_NOT = 5'd3;
	localparam logic [4:0] OP_ADD = 5'd4;
	localparam logic [4:0] OP_SUB = 5'd5;
	localparam logic [4:0] OP_MUL = 5'd6;
	localparam logic [4:0] OP_DIV = 5'd7;
	localparam logic [4:0] OP_MOD = 5'd8;
	localparam logic [4:0] OP_PCT = 5'd9;
	localparam logic [4:0] OP_SQRT = 5'd10;
	localparam logic [4:0] OP_SQR = 5'd11;
	localparam logic [4:0] OP_NZ = 5'd12;
	localparam logic [4:0] OP_ZERO = 5'd13;
	localparam logic [4:0] OP_ONE = 5'd14;
	localparam logic [4:0] OP_MEM0 = 5'd15;
	localparam logic [4:0] OP_MEM1 = 5'd16;
	localparam logic [4:0] OP_MEM2 = 5'd17;
	localparam logic [4:0] OP_GT = 5'd18;
	localparam logic [4:0] OP_LT = 5'd19;
	localparam logic [4:0] OP_EQ = 5'd20;
	localparam logic [4:0] OP_MAX = 5'd21;
	localparam logic [4:0] OP_MIN = 5'd22;
	localparam logic [4:0] OP_PASS = 5'd23;

	localparam logic signed [31:0] FX_ONE = 32'sd1 <<< FRACTION_BITS;
	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;

	typedef struct packed {
		logic [4:0] mode;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} req_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic overflow;
		logic invalid;
	} rsp_t;

	// saturate a 66-bit signed value to 32 bits
	function automatic logic [32:0] sat66(input logic signed [65:0] v);
		logic [32:0] r;
		if (v > 66'sh0_7fff_ffff) r = {S32_MAX, 1'b1};
		else if (v < -66'sh0_8000_0000) r = {S32_MIN, 1'b1};
		else r = {v[31:0], 1'b0};
		return r;
	endfunction
endpackage

@@ sv/noa_mul.sv @@
// Bit-serial shift-add multiplier: 64-bit magnitude product, one bit a cycle.
// Depends on noa_pkg.
module noa_mul (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] mcand,
	input logic [31:0] mplier,
	output logic done,
	output logic [63:0] prod
);
	import noa_pkg::*;

	logic [63:0] acc_q;
	logic [31:0] mpl_q;
	logic [31:0] mc_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			// flag the cycle after the last step, once the product is complete
			done_q <= busy_q && !start && (cnt_q == 6'd31);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) busy_q <= 1'b0;
			end
		end
	end

	// add the multiplicand at the top, then shift right
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mpl_q <= mplier;
			mc_q <= mcand;
		end else if (busy_q) begin
			logic [32:0] top;
			top = {1'b0, acc_q[63:32]} + (mpl_q[0] ? {1'b0, mc_q} : 33'd0);
			acc_q <= {top, acc_q[31:1]};
			mpl_q <= mpl_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

@@ sv/noa_div.sv @@
// Bit-serial restoring divider and square root on unsigned 64-bit values,
// one quotient or root bit a cycle. Depends on noa_pkg.
module noa_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic sqrt_mode,
	input logic [63:0] num,
	input logic [63:0] den,
	output logic done,
	output logic [63:0] quo,
	output logic [63:0] rem
);
	import noa_pkg::*;

	logic [63:0] n_q;
	logic [63:0] d_q;
	logic [63:0] q_q;
	logic [65:0] r_q;
	logic [6:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic sq_q;
	logic [6:0] last;

	assign last = sq_q ? 7'd31 : 7'd63;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			// flag the cycle after the last step, once quotient and remainder settle
			done_q <= busy_q && !start && (cnt_q == last);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == last) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			q_q <= '0;
			r_q <= '0;
			sq_q <= sqrt_mode;
		end else if (busy_q) begin
			logic [65:0] rs;
			logic [65:0] trial;
			if (sq_q) begin
				// bring down two bits, trial is 4q+1
				rs = {r_q[63:0], n_q[63:62]};
				trial = {q_q[63:0], 2'b01};
				n_q <= n_q << 2;
			end else begin
				rs = {r_q[64:0], n_q[63]};
				trial = {2'b00, d_q};
				n_q <= n_q << 1;
			end
			if (rs >= trial) begin
				r_q <= rs - trial;
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = q_q;
	assign rem = r_q[63:0];
endmodule

@@ sv/node_operation_alu.sv @@
// Signed Q16.16 ALU. One request at a time: logic, compare, add and memory
// ops finish in the decode state; multiply and square use the bit-serial
// multiplier, divide and remainder the one-bit-a-cycle divider, a*b/100
// the multiplier then the divider, and square root the divider.
// The result is held in an output register until taken; the next request is
// taken once it is gone.
module node_operation_alu (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input noa_pkg::req_t in_data,
	output logic out_valid,
	input logic out_stall,
	output noa_pkg::rsp_t out_data
);
	import noa_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL = 3'd1;
	localparam logic [2:0] ST_DIV = 3'd2;
	localparam logic [2:0] ST_OUT = 3'd3;

	logic [2:0] state_q;
	req_t req_q;
	rsp_t rsp_q;
	logic [31:0] slot_q [SLOT_COUNT];

	logic signed [32:0] sum, diff;
	logic [32:0] mag_s;
	logic sgn_a, sgn_b;
	logic [31:0] mag_a, mag_b;
	logic mul_start, mul_done, div_start, div_done;
	logic [31:0] mc, mp;
	logic [63:0] prod, quo, rem, dnum, dden;
	logic dsq;
	logic signed [31:0] a, b;
	logic accept;

	assign a = req_q.operand_a;
	assign b = req_q.operand_b;
	assign sum = {a[31], a} + {b[31], b};
	assign diff = {a[31], a} - {b[31], b};
	assign mag_s = sum[32] ? 33'(-sum) : 33'(sum);
	assign sgn_a = a[31];
	assign sgn_b = b[31];
	assign mag_a = sgn_a ? 32'(-a) : 32'(a);
	assign mag_b = sgn_b ? 32'(-b) : 32'(b);

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);
	assign out_data = rsp_q;

	logic started_q;

	noa_mul u_mul (.clk, .arst_n, .start(mul_start), .mcand(mc), .mplier(mp),
		.done(mul_done), .prod(prod));
	noa_div u_div (.clk, .arst_n, .start(div_start), .sqrt_mode(dsq), .num(dnum),
		.den(dden), .done(div_done), .quo(quo), .rem(rem));

	always_comb begin
		mc = mag_a;
		mp = mag_b;
		if (req_q.mode == OP_SQR) begin
			mc = mag_s[31:0];
			mp = mag_s[31:0];
		end
	end

	logic [63:0] pct_den;
	assign pct_den = 64'(100) << FRACTION_BITS;

	always_comb begin
		dsq = (req_q.mode == OP_SQRT);
		dnum = 64'({32'd0, mag_a}) << FRACTION_BITS;
		dden = {32'd0, mag_b};
		case (req_q.mode)
			OP_MOD: dnum = {32'd0, mag_a};
			OP_PCT: begin
				dnum = prod;
				dden = pct_den;
			end
			OP_SQRT: dnum = 64'(sum[31:0]) << FRACTION_BITS;
			default: ;
		endcase
	end

	// quick-path result
	rsp_t fast;
	logic fast_only, need_mul;
	always_comb begin
		logic [32:0] s;
		logic [SLOT_W-1:0] sl;
		logic [4:0] off;
		fast = '0;
		fast_only = 1'b1;
		need_mul = 1'b0;
		s = '0;
		off = req_q.mode - OP_MEM0;
		sl = off[SLOT_W-1:0];
		case (req_q.mode)
			OP_AND: fast.result = (a != 0 && b != 0) ? FX_ONE : 32'sd0;
			OP_OR: fast.result = (a != 0 || b != 0) ? FX_ONE : 32'sd0;
			OP_XOR: fast.result = ((a != 0) != (b != 0)) ? FX_ONE : 32'sd0;
			OP_NOT: fast.result = (a != 0) ? 32'sd0 : FX_ONE;
			OP_ADD: begin
				s = sat66(66'(sum));
				fast.result = s[32:1];
				fast.overflow = s[0];
			end
			OP_SUB: begin
				s = sat66(66'(diff));
				fast.result = s[32:1];
				fast.overflow = s[0];
			end
			OP_MUL, OP_PCT: begin
				fast_only = 1'b0;
				need_mul = 1'b1;
			end
			OP_SQR: begin
				if (mag_s[32]) begin
					fast.result = S32_MAX;
					fast.overflow = 1'b1;
				end else begin
					fast_only = 1'b0;
					need_mul = 1'b1;
				end
			end
			OP_DIV: fast_only = (b == 0);
			OP_MOD: begin
				fast_only = (b == 0);
				fast.invalid = (b == 0);
			end
			OP_SQRT: begin
				fast_only = sum[32];
				fast.invalid = sum[32];
			end
			OP_NZ: fast.result = (sum != 0) ? FX_ONE : 32'sd0;
			OP_ONE: fast.result = FX_ONE;
			OP_MEM0, OP_MEM1, OP_MEM2: begin
				if (b == FX_ONE) fast.result = a;
				else if (32'(off) < SLOT_COUNT) fast.result = slot_q[sl];
			end
			OP_GT: fast.result = (a > b) ? FX_ONE : 32'sd0;
			OP_LT: fast.result = (a < b) ? FX_ONE : 32'sd0;
			OP_EQ: fast.result = (a == b) ? FX_ONE : 32'sd0;
			OP_MAX: fast.result = (a > b) ? a : b;
			OP_MIN: fast.result = (a < b) ? a : b;
			OP_PASS: fast.result = a;
			default: ;
		endcase
	end

	// slow-path results from the serial units
	rsp_t slow_mul, slow_div;
	always_comb begin
		logic signed [65:0] v;
		logic [32:0] s;
		logic neg;
		neg = sgn_a ^ sgn_b;
		slow_mul = '0;
		if (req_q.mode == OP_SQR) begin
			v = 66'(prod >> FRACTION_BITS);
		end else begin
			// floor of signed product over 2^F
			v = neg ? -66'(64'((prod + 64'((64'd1 << FRACTION_BITS) - 1)) >>
				FRACTION_BITS)) : 66'(prod >> FRACTION_BITS);
			if (neg && prod != 0) v = -66'((prod - 64'd1) >> FRACTION_BITS) - 66'sd1;
		end
		s = sat66(v);
		slow_mul.result = s[32:1];
		slow_mul.overflow = s[0];

		slow_div = '0;
		case (req_q.mode)
			OP_MOD: slow_div.result = sgn_a ? 32'(-rem[31:0]) : rem[31:0];
			OP_SQRT: slow_div.result = quo[31:0];
			default: begin
				v = neg ? -66'(quo) : 66'(quo);
				s = sat66(v);
				slow_div.result = s[32:1];
				slow_div.overflow = s[0];
			end
		endcase
	end

	assign mul_start = (state_q == ST_MUL) && !started_q && need_mul;
	assign div_start = (state_q == ST_DIV) && !started_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			started_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) slot_q[i] <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) begin
					state_q <= ST_MUL;
					started_q <= 1'b0;
				end
				ST_MUL: begin
					// first cycle in ST_MUL decodes the registered request
					if (!started_q) begin
						if (fast_only) begin
							state_q <= ST_OUT;
							if ((req_q.mode == OP_MEM0 || req_q.mode == OP_MEM1 ||
								req_q.mode == OP_MEM2) && b == FX_ONE &&
								32'(req_q.mode - OP_MEM0) < SLOT_COUNT)
								slot_q[SLOT_W'(req_q.mode - OP_MEM0)] <= a;
						end else if (!need_mul) begin
							state_q <= ST_DIV;
						end else begin
							started_q <= 1'b1;
						end
					end else if (mul_done) begin
						started_q <= 1'b0;
						if (req_q.mode == OP_PCT) state_q <= ST_DIV;
						else state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					if (!started_q) started_q <= 1'b1;
					else if (div_done) begin
						started_q <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic mul_wait;
	assign mul_wait = (state_q == ST_MUL) && started_q;

	always_ff @(posedge clk) begin
		if (accept) req_q <= in_data;
		if (state_q == ST_MUL && !started_q && fast_only) rsp_q <= fast;
		else if (mul_wait && mul_done && req_q.mode != OP_PCT) rsp_q <= slow_mul;
		else if (state_q == ST_DIV && started_q && div_done) rsp_q <= slow_div;
	end

	// the slot store happens only on the decode cycle of a memory request
	assert property (@(posedge clk) disable iff (!arst_n)
		$changed(slot_q[0]) |-> $past(state_q == ST_MUL && !started_q))
		else $error("slot written outside a memory request");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_stall) |=> (state_q == ST_OUT && $stable(rsp_q)))
		else $error("held result changed");
	assert property (@(posedge clk) disable iff (!arst_n)
		(mul_done || div_done) |-> (state_q == ST_MUL || state_q == ST_DIV))
		else $error("serial unit finished outside its state");
endmodule

@@ tb/tb.sv @@
// Self-checking testbench for node_operation_alu: a directed table, then random requests.
// Depends on noa_pkg and node_operation_alu; predicts every response locally.
`timescale 1ns / 1ps

module tb;
	import noa_pkg::*;

	localparam int RANDOM_REQS = 1800;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [4:0] mode;
		logic signed [31:0] a;
		logic signed [31:0] b;
		bit known;
		rsp_t rsp;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t out_data;

	logic signed [31:0] slot_shadow [SLOT_COUNT];
	rsp_t expected_rsps [$];
	int errors = 0;
	int rsp_count = 0;
	int idle_cycles = 0;
	bit stim_done = 1'b0;
	bit drain_done = 1'b0;
	int ovf_seen = 0;
	int inv_seen = 0;

	node_operation_alu u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #10 clk = ~clk;

	function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v, inout bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= r + bitv) begin
				v = v - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	// compute one response and advance the slot shadow
	function automatic rsp_t alu_predict(input logic [4:0] mode, input logic signed [31:0] a32,
			input logic signed [31:0] b32);
		logic signed [63:0] a, b, s, r, p, one;
		logic [63:0] m, q;
		bit ovf, inv, na, nb;
		int slot;
		rsp_t rsp;
		a = a32;
		b = b32;
		s = a + b;
		r = 0;
		ovf = 0;
		inv = 0;
		na = (a != 0);
		nb = (b != 0);
		one = 64'sd1 <<< FRACTION_BITS;
		case (mode)
			OP_AND: r = (na && nb) ? one : 0;
			OP_OR: r = (na || nb) ? one : 0;
			OP_XOR: r = (na != nb) ? one : 0;
			OP_NOT: r = na ? 0 : one;
			OP_ADD: r = clamp_q(s, ovf);
			OP_SUB: r = clamp_q(a - b, ovf);
			OP_MUL: begin
				p = a * b;
				r = clamp_q(p >>> FRACTION_BITS, ovf);
			end
			OP_DIV: if (b != 0) r = clamp_q((a * one) / b, ovf);
			OP_MOD: begin
				if (b != 0) r = a % b;
				else inv = 1;
			end
			OP_PCT: r = clamp_q((a * b) / (one * 100), ovf);
			OP_SQRT: begin
				if (s < 0) inv = 1;
				else r = root_floor(s << FRACTION_BITS);
			end
			OP_SQR: begin
				m = (s < 0) ? -s : s;
				if (m > 64'hFFFF_FFFF) begin
					r = 64'sd2147483647;
					ovf = 1;
				end else begin
					q = (m * m) >> FRACTION_BITS;
					if (q > 64'd2147483647) begin
						r = 64'sd2147483647;
						ovf = 1;
					end else begin
						r = q;
					end
				end
			end
			OP_NZ: r = (s == 0) ? 0 : one;
			OP_ZERO: r = 0;
			OP_ONE: r = one;
			OP_MEM0, OP_MEM1, OP_MEM2: begin
				slot = mode - OP_MEM0;
				if (b == one) begin
					if (slot < SLOT_COUNT) slot_shadow[slot] = a32;
					r = a;
				end else if (slot < SLOT_COUNT) begin
					r = slot_shadow[slot];
				end
			end
			OP_GT: r = (a > b) ? one : 0;
			OP_LT: r = (a < b) ? one : 0;
			OP_EQ: r = (a == b) ? one : 0;
			OP_MAX: r = (a > b) ? a : b;
			OP_MIN: r = (a < b) ? a : b;
			OP_PASS: r = a;
			default: r = 0;
		endcase
		rsp.result = r[31:0];
		rsp.overflow = ovf;
		rsp.invalid = inv;
		return rsp;
	endfunction

	function automatic logic signed [31:0] pick_operand();
		case ($urandom_range(0, 9))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return 0;
			3: return FX_ONE;
			4: return -FX_ONE;
			5: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
			6: return $signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000;
			default: return $urandom();
		endcase
	endfunction

	// check responses, pace the receiver and keep the watchdog
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (out_valid && !out_stall) begin
			if (expected_rsps.size() == 0) begin
				$error("response with nothing expected: result %h", out_data.result);
				errors++;
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (out_data.result !== exp_rsp.result) begin
					$error("result: expected %h actual %h", exp_rsp.result, out_data.result);
					errors++;
				end
				if (out_data.overflow !== exp_rsp.overflow) begin
					$error("overflow: expected %b actual %b", exp_rsp.overflow, out_data.overflow);
					errors++;
				end
				if (out_data.invalid !== exp_rsp.invalid) begin
					$error("invalid: expected %b actual %b", exp_rsp.invalid, out_data.invalid);
					errors++;
				end
				ovf_seen += exp_rsp.overflow;
				inv_seen += exp_rsp.invalid;
			end
			rsp_count++;
		end
		// stall in phases: quiet stretches, light and heavy back-pressure
		case ((rsp_count / 150) % 3)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 3) != 0);
		endcase
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
		else if (arst_n) idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("node_operation_alu verification failed");
			$finish;
		end
	end

	task automatic send_req(input logic [4:0] mode, input logic signed [31:0] a,
			input logic signed [31:0] b, input bit known, input rsp_t fixed);
		rsp_t pred;
		in_data <= '{mode: mode, operand_a: a, operand_b: b};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		pred = alu_predict(mode, a, b);
		if (known && pred !== fixed) begin
			$error("table row mode %0d: typed %h predicted %h", mode, fixed, pred);
			errors++;
		end
		expected_rsps.push_back(pred);
	endtask

	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	stim_row_t rows [$];

	initial begin
		rsp_t none;
		int burst;
		int sent;
		logic [4:0] mode;
		logic signed [31:0] a, b;
		none = '0;
		foreach (slot_shadow[i]) slot_shadow[i] = 0;
		rows = '{
			'{OP_MEM0, 32'sh1234_5678, 0, 1, '{0, 0, 0}},
			'{OP_MEM2, 5, -1, 1, '{0, 0, 0}},
			'{OP_ADD, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, '{32'sh7fff_ffff, 1, 0}},
			'{OP_SUB, 32'sh8000_0000, 1, 1, '{32'sh8000_0000, 1, 0}},
			'{OP_DIV, 32'sh0003_0000, 0, 1, '{0, 0, 0}},
			'{OP_MOD, 32'sh0003_0000, 0, 1, '{0, 0, 1}},
			'{OP_SQRT, -5, 2, 1, '{0, 0, 1}},
			'{OP_SQRT, 32'sh0004_0000, 0, 1, '{32'sh0002_0000, 0, 0}},
			'{OP_SQR, 32'sh7fff_ffff, 32'sh7fff_ffff, 1, '{32'sh7fff_ffff, 1, 0}},
			'{OP_MUL, 32'sh8000_0000, 32'sh8000_0000, 1, '{32'sh7fff_ffff, 1, 0}},
			'{OP_MUL, -1, 1, 0, none},
			'{OP_DIV, 32'sh8000_0000, -1, 0, none},
			'{OP_MOD, -7, 3, 0, none},
			'{OP_PCT, 32'sh7fff_ffff, 32'sh8000_0000, 0, none},
			'{OP_AND, 3, 0, 1, '{0, 0, 0}},
			'{OP_OR, 0, 32'sh8000_0000, 1, '{FX_ONE, 0, 0}},
			'{OP_XOR, 1, 1, 1, '{0, 0, 0}},
			'{OP_NOT, 0, 9, 1, '{FX_ONE, 0, 0}},
			'{OP_NZ, 32'sh7fff_ffff, 32'sh8000_0001, 1, '{0, 0, 0}},
			'{OP_ZERO, -1, -1, 1, '{0, 0, 0}},
			'{OP_ONE, 0, 0, 1, '{FX_ONE, 0, 0}},
			'{OP_MEM1, -3, FX_ONE, 1, '{-3, 0, 0}},
			'{OP_MEM1, 0, 0, 1, '{-3, 0, 0}},
			'{OP_GT, 1, 32'sh8000_0000, 0, none},
			'{OP_LT, 1, 32'sh8000_0000, 0, none},
			'{OP_EQ, 32'sh8000_0000, 32'sh8000_0000, 1, '{FX_ONE, 0, 0}},
			'{OP_MAX, -1, 32'sh8000_0000, 1, '{-1, 0, 0}},
			'{OP_MIN, -1, 32'sh8000_0000, 1, '{32'sh8000_0000, 0, 0}},
			'{OP_PASS, 32'sh8000_0000, 0, 1, '{32'sh8000_0000, 0, 0}},
			'{5'd31, 7, 7, 1, '{0, 0, 0}}
		};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) send_req(rows[i].mode, rows[i].a, rows[i].b, rows[i].known,
			rows[i].rsp);
		sent = 0;
		while (sent < RANDOM_REQS) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && sent < RANDOM_REQS; k++) begin
				mode = 5'($urandom_range(0, 31));
				if ($urandom_range(0, 7) != 0) mode = 5'($urandom_range(0, 23));
				a = pick_operand();
				b = pick_operand();
				if (mode >= OP_MEM0 && mode <= OP_MEM2 && $urandom_range(0, 1)) b = FX_ONE;
				send_req(mode, a, b, 0, none);
				sent++;
			end
			if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 60));
		end
		in_valid <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		$display("covered %0d requests over all opcodes, %0d responses", rows.size() + sent,
			rsp_count);
		$display("saturated responses: %0d, invalid responses: %0d", ovf_seen, inv_seen);
		if (errors == 0) $display("node_operation_alu verification clean");
		else $display("node_operation_alu verification failed");
		$finish;
	end
endmodule
